// File: rtl/core/positional_array_list_assert.svh
// ----------------------------------------------------------------------------
// positional array list assertion macros
// concurrent assertion wrappers used by the checker file
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// checked on every rising edge outside reset
`define PAL_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("positional array list assertion failed");

// checked on every rising edge, reset included
`define PAL_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("positional array list assertion failed");

`endif

// File: rtl/core/pal_pkg.sv
// ----------------------------------------------------------------------------
// positional array list package
// field widths, operation codes and the per-slot control word
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int OP_W  = 3;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int CNT_W = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_GET    = 3'd2;
    localparam logic [OP_W-1:0] OP_LOCATE = 3'd3;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd4;

    // what a slot takes at the next edge
    typedef struct packed {
        logic load;       // new value from the request
        logic from_prev;  // shift up: take the lower neighbour
        logic from_next;  // shift down: take the upper neighbour
    } pal_slot_ctrl_t;

endpackage

// File: rtl/core/pal_req_if.sv
// ----------------------------------------------------------------------------
// positional array list request channel
// valid/ready channel carrying one list operation
// ----------------------------------------------------------------------------
interface pal_req_if
    import pal_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output operation, output position, output value,
                    input ready);
    modport sink   (input valid, input operation, input position, input value,
                    output ready);
endinterface

// File: rtl/core/pal_rsp_if.sv
// ----------------------------------------------------------------------------
// positional array list response channel
// valid/ready channel carrying one operation result
// ----------------------------------------------------------------------------
interface pal_rsp_if
    import pal_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    ok;
    logic signed [VAL_W-1:0] read_value;
    logic [POS_W-1:0]        found_position;
    logic [CNT_W-1:0]        count;

    modport source (output valid, output ok, output read_value, output found_position,
                    output count, input ready);
    modport sink   (input valid, input ok, input read_value, input found_position,
                    input count, output ready);
endinterface

// File: rtl/core/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional array list
// ordered list of up to DEPTH signed values held in a row of shifting slots
// ----------------------------------------------------------------------------
// The list lives in a chain of DEPTH slots, slot 0 at the head. Each request
// transaction is taken and finished at the same clock edge: insert shifts every slot at
// or above the position up by one and loads the new value, delete shifts the
// slots above the position down by one, append loads the slot at the tail,
// and get and locate read the chain without changing it. Locate compares the
// key in every slot at once and picks the lowest match below the length. The
// result is registered, so a response appears in the cycle after its request
// and a new request is taken whenever the response register is empty or being
// emptied; without back-pressure the sustained rate is one request per cycle,
// set by the single pass through the slot compare and shift logic.
// Positions are 1-based; a request with a bad position, an insert or append
// on a full list, a delete or get on an empty list, or an unused operation
// code reports ok low and leaves the list unchanged. Slot contents are
// undefined after reset and are only ever read below the current length.
// ----------------------------------------------------------------------------
module positional_array_list
    import pal_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    pal_req_if.sink   req,
    pal_rsp_if.source rsp
);
    // length register width and a common compare width
    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

    // list length
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;

    // response register
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    logic                    rsp_ok_reg;
    logic                    rsp_ok_next;
    logic signed [VAL_W-1:0] rsp_read_reg;
    logic signed [VAL_W-1:0] rsp_read_next;
    logic [POS_W-1:0]        rsp_fpos_reg;
    logic [POS_W-1:0]        rsp_fpos_next;
    logic [CNT_W-1:0]        rsp_count_reg;
    logic [CNT_W-1:0]        rsp_count_next;

    // slot chain
    pal_slot_ctrl_t          slot_ctrl [DEPTH];
    logic signed [VAL_W-1:0] slot_entry [DEPTH];
    logic [DEPTH-1:0]        slot_match;

    // decoded request
    logic             accept;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] idx_ext;
    logic             ins_ok;
    logic             del_ok;
    logic             get_ok;
    logic             app_ok;
    logic             is_locate;
    logic             hit;
    logic [POS_W-1:0] hit_pos;
    logic signed [VAL_W-1:0] rd_data;

    // a new transaction is taken while the response register is free or draining
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign pos_ext = CMP_W'(req.position);
    assign len_ext = CMP_W'(len_reg);
    assign idx_ext = pos_ext - CMP_W'(1);

    // operation checks
    always_comb
    begin
        ins_ok    = 1'b0;
        del_ok    = 1'b0;
        get_ok    = 1'b0;
        app_ok    = 1'b0;
        is_locate = 1'b0;
        case (req.operation)
            OP_INSERT:
            begin
                ins_ok = (pos_ext != '0) && (pos_ext <= len_ext + CMP_W'(1))
                         && (len_ext < CMP_W'(DEPTH));
            end
            OP_DELETE:
            begin
                del_ok = (pos_ext != '0) && (pos_ext <= len_ext);
            end
            OP_GET:
            begin
                get_ok = (pos_ext != '0) && (pos_ext <= len_ext);
            end
            OP_LOCATE:
            begin
                is_locate = 1'b1;
            end
            OP_APPEND:
            begin
                app_ok = (len_ext < CMP_W'(DEPTH));
            end
            default:
            begin
                ins_ok = 1'b0;
            end
        endcase
    end

    // per-slot shift and load controls
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_ctrl[i].load      = accept && ((ins_ok && (CMP_W'(i) == idx_ext))
                                     || (app_ok && (CMP_W'(i) == len_ext)));
            slot_ctrl[i].from_prev = accept && ins_ok && (CMP_W'(i) > idx_ext)
                                     && (CMP_W'(i) <= len_ext);
            slot_ctrl[i].from_next = accept && del_ok && (CMP_W'(i) >= idx_ext)
                                     && (CMP_W'(i) + CMP_W'(1) < len_ext);
        end
    end

    // the chain of slots, each fed by both neighbours
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_slot
        logic signed [VAL_W-1:0] prev_w;
        logic signed [VAL_W-1:0] next_w;

        if (g == 0)
        begin : g_head
            assign prev_w = slot_entry[g];
        end
        else
        begin : g_body
            assign prev_w = slot_entry[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign next_w = slot_entry[g];
        end
        else
        begin : g_inner
            assign next_w = slot_entry[g+1];
        end

        pal_slot u_slot (
            .clk       (clk),
            .ctrl      (slot_ctrl[g]),
            .value_in  (req.value),
            .prev_data (prev_w),
            .next_data (next_w),
            .key       (req.value),
            .entry     (slot_entry[g]),
            .match     (slot_match[g])
        );
    end

    // read at the requested position
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (CMP_W'(i) == idx_ext)
            begin
                rd_data = slot_entry[i];
            end
        end
    end

    // first match below the length, lowest slot wins
    always_comb
    begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (slot_match[i] && (CMP_W'(i) < len_ext))
            begin
                hit     = 1'b1;
                hit_pos = POS_W'(i + 1);
            end
        end
    end

    // length and response
    always_comb
    begin
        len_next       = len_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_ok_next    = rsp_ok_reg;
        rsp_read_next  = rsp_read_reg;
        rsp_fpos_next  = rsp_fpos_reg;
        rsp_count_next = rsp_count_reg;
        if (accept)
        begin
            if (ins_ok || app_ok)
            begin
                len_next = len_reg + LEN_W'(1);
            end
            else if (del_ok)
            begin
                len_next = len_reg - LEN_W'(1);
            end
            rsp_valid_next = 1'b1;
            rsp_ok_next    = ins_ok || app_ok || del_ok || get_ok || (is_locate && hit);
            rsp_read_next  = (del_ok || get_ok) ? rd_data : '0;
            rsp_fpos_next  = (is_locate && hit) ? hit_pos : '0;
            rsp_count_next = CNT_W'(len_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // response payload, no reset
    always_ff @(posedge clk)
    begin
        rsp_ok_reg    <= rsp_ok_next;
        rsp_read_reg  <= rsp_read_next;
        rsp_fpos_reg  <= rsp_fpos_next;
        rsp_count_reg <= rsp_count_next;
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.ok             = rsp_ok_reg;
    assign rsp.read_value     = rsp_read_reg;
    assign rsp.found_position = rsp_fpos_reg;
    assign rsp.count          = rsp_count_reg;
endmodule

// File: rtl/core/pal_slot.sv
// ----------------------------------------------------------------------------
// positional array list slot
// one list entry with load, shift-up and shift-down paths and a key compare
// ----------------------------------------------------------------------------
module pal_slot
    import pal_pkg::*;
(
    input  logic                    clk,
    input  pal_slot_ctrl_t          ctrl,
    input  logic signed [VAL_W-1:0] value_in,
    input  logic signed [VAL_W-1:0] prev_data,
    input  logic signed [VAL_W-1:0] next_data,
    input  logic signed [VAL_W-1:0] key,
    output logic signed [VAL_W-1:0] entry,
    output logic                    match
);
    logic signed [VAL_W-1:0] entry_reg;
    logic signed [VAL_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load)
        begin
            entry_next = value_in;
        end
        else if (ctrl.from_prev)
        begin
            entry_next = prev_data;
        end
        else if (ctrl.from_next)
        begin
            entry_next = next_data;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = (entry_reg == key);
endmodule

// File: rtl/core/pal_checker.sv
// ----------------------------------------------------------------------------
// positional array list checker
// port-level assertions, bound to the top level
// ----------------------------------------------------------------------------
`include "positional_array_list_assert.svh"

module pal_checker
    import pal_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_valid,
    input logic                    req_ready,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input logic                    rsp_ok,
    input logic signed [VAL_W-1:0] rsp_read_value,
    input logic [POS_W-1:0]        rsp_found_position,
    input logic [CNT_W-1:0]        rsp_count
);
    // every request transaction gives a response in the next cycle
    `PAL_ASSERT(a_rsp_follows_req, req_valid && req_ready |=> rsp_valid)

    // a stalled response stays and holds its count and ok flag
    `PAL_ASSERT(a_rsp_held, rsp_valid && !rsp_ready |=> rsp_valid)
    `PAL_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_count) && $stable(rsp_ok))

    // a failed operation reports no data and no position
    `PAL_ASSERT(a_fail_clean,
        rsp_valid && !rsp_ok |-> rsp_read_value == '0 && rsp_found_position == '0)

    // a reported position is always a successful locate
    `PAL_ASSERT(a_pos_ok, rsp_valid && rsp_found_position != '0 |-> rsp_ok)
endmodule

bind positional_array_list pal_checker u_pal_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_ok             (rsp.ok),
    .rsp_read_value     (rsp.read_value),
    .rsp_found_position (rsp.found_position),
    .rsp_count          (rsp.count)
);

// File: tb/sv/positional_array_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional array list testbench
// ----------------------------------------------------------------------------
// Drives list operations on the request channel and checks every response
// against a predictor of the list that runs as each request is taken.
// A short directed part covers the empty list, shifts at the head, middle and
// tail, duplicate keys, value extremes and the full list. A random part then
// wanders the length between empty and full. Both channels idle at random,
// except in one stretch where they run flat out.
// ----------------------------------------------------------------------------
module positional_array_list_tb;

    import pal_pkg::*;

    localparam int LIST_DEPTH   = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PERCENT = 29;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 10;

    // first code past the defined operations; everything from here up must fail
    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_APPEND + OP_W'(1);

    // what one response transaction should carry
    typedef struct {
        logic                    ok;
        logic signed [VAL_W-1:0] read_value;
        logic [POS_W-1:0]        found_position;
        logic [CNT_W-1:0]        count;
    } list_result_t;

    logic clk;
    logic rst_n;

    pal_req_if req_if ();
    pal_rsp_if rsp_if ();

    positional_array_list #(
        .DEPTH (LIST_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // predictor state: list contents and length as the block should hold them
    logic signed [VAL_W-1:0] shadow_list [LIST_DEPTH];
    int                      shadow_len;

    list_result_t pending_results [$];
    int           mismatch_count;
    int           cycle_count;
    bit           flat_out;     // no idling on either side while set

    // ------------------------------------------------------------------------
    // clock, 12 ns period
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor: apply one operation to the shadow list, return the response
    // ------------------------------------------------------------------------
    function automatic list_result_t apply_list_op(logic [OP_W-1:0] op,
                                                   logic [POS_W-1:0] pos,
                                                   logic signed [VAL_W-1:0] val);
        list_result_t res;
        int           p;
        res.ok             = 1'b0;
        res.read_value     = '0;
        res.found_position = '0;
        p = int'(pos);
        case (op)
            OP_INSERT:
            begin
                // position may be one past the tail, list must have room
                if (p >= 1 && p <= shadow_len + 1 && shadow_len < LIST_DEPTH)
                begin
                    for (int j = shadow_len; j >= p; j--)
                        shadow_list[j] = shadow_list[j-1];
                    shadow_list[p-1] = val;
                    shadow_len++;
                    res.ok = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (p >= 1 && p <= shadow_len)
                begin
                    res.read_value = shadow_list[p-1];
                    for (int j = p; j < shadow_len; j++)
                        shadow_list[j-1] = shadow_list[j];
                    shadow_len--;
                    res.ok = 1'b1;
                end
            end
            OP_GET:
            begin
                if (p >= 1 && p <= shadow_len)
                begin
                    res.read_value = shadow_list[p-1];
                    res.ok         = 1'b1;
                end
            end
            OP_LOCATE:
            begin
                // first match wins
                for (int j = 0; j < shadow_len; j++)
                begin
                    if (!res.ok && shadow_list[j] == val)
                    begin
                        res.found_position = POS_W'(j + 1);
                        res.ok             = 1'b1;
                    end
                end
            end
            OP_APPEND:
            begin
                if (shadow_len < LIST_DEPTH)
                begin
                    shadow_list[shadow_len] = val;
                    shadow_len++;
                    res.ok = 1'b1;
                end
            end
            default:
            begin
                // unused codes leave the list alone
            end
        endcase
        res.count = CNT_W'(shadow_len);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // send one request transaction; the expectation is queued when it is taken
    // valid is left high on return so back-to-back requests stay contiguous
    // ------------------------------------------------------------------------
    task automatic issue_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic signed [VAL_W-1:0] val);
        @(negedge clk);
        while (!flat_out && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.position  <= pos;
        req_if.value     <= val;
        do
            @(posedge clk);
        while (!req_if.ready);
        pending_results.push_back(apply_list_op(op, pos, val));
    endtask

    // ------------------------------------------------------------------------
    // response side: random back-pressure, driven at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
            rsp_if.ready <= flat_out || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // ------------------------------------------------------------------------
    // response checker: each taken transaction against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("[%0t] unexpected response: ok=%0b read=%0d found=%0d count=%0d",
                             $realtime, rsp_if.ok, rsp_if.read_value,
                             rsp_if.found_position, rsp_if.count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_if.ok !== want.ok || rsp_if.read_value !== want.read_value ||
                    rsp_if.found_position !== want.found_position ||
                    rsp_if.count !== want.count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"[%0t] mismatch: expected ok=%0b read=%0d found=%0d ",
                                  "count=%0d, got ok=%0b read=%0d found=%0d count=%0d"},
                                 $realtime, want.ok, want.read_value, want.found_position,
                                 want.count, rsp_if.ok, rsp_if.read_value,
                                 rsp_if.found_position, rsp_if.count);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // empty list: every read and delete fails, insert only at position 1
    // ------------------------------------------------------------------------
    task automatic test_empty_list();
        issue_request(OP_GET,    5'd1, 32'sd7);
        issue_request(OP_DELETE, 5'd1, 32'sd0);
        issue_request(OP_LOCATE, 5'd0, 32'sd0);
        issue_request(OP_INSERT, 5'd0, 32'sd3);      // position below range
        issue_request(OP_INSERT, 5'd2, 32'sd3);      // past length plus one
        issue_request(OP_FIRST_UNUSED, 5'd1, 32'sd1);
    endtask

    // ------------------------------------------------------------------------
    // shifts at head, middle and tail, duplicate keys, value extremes
    // ------------------------------------------------------------------------
    task automatic test_shifts();
        issue_request(OP_INSERT, 5'd1, 32'sd5);
        issue_request(OP_INSERT, 5'd1, 32'sh8000_0000);   // new head
        issue_request(OP_INSERT, 5'd3, 32'sh7fff_ffff);   // tail, length plus one
        issue_request(OP_INSERT, 5'd2, -32'sd1);          // middle
        issue_request(OP_APPEND, 5'd31, 32'sd5);          // duplicate key at the tail
        issue_request(OP_LOCATE, 5'd31, 32'sd5);          // must report the first copy
        issue_request(OP_DELETE, 5'd1, 32'sd0);           // head
        issue_request(OP_DELETE, 5'd4, 32'sd0);           // tail
        issue_request(OP_DELETE, 5'd2, 32'sd0);           // middle
        issue_request(OP_GET,    5'd1, 32'sd0);
    endtask

    // ------------------------------------------------------------------------
    // full list: append and insert are refused, the last slot reads back
    // ------------------------------------------------------------------------
    task automatic test_full_list();
        while (shadow_len < LIST_DEPTH)
            issue_request(OP_APPEND, 5'd0, $signed($urandom()));
        issue_request(OP_APPEND, 5'd0, 32'sd9);
        issue_request(OP_INSERT, 5'd1, 32'sd9);
        issue_request(OP_GET,    5'(LIST_DEPTH), 32'sd0);
        issue_request(OP_GET,    5'(LIST_DEPTH + 1), 32'sd0);
        issue_request(OP_GET,    5'd31, 32'sd0);
    endtask

    // pick one of the unused operation codes
    function automatic logic [OP_W-1:0] OP_OP_UNUSED_PICK();
        return OP_W'($urandom_range(int'(OP_FIRST_UNUSED), (1 << OP_W) - 1));
    endfunction

    // ------------------------------------------------------------------------
    // random traffic in phases that alternately grow and shrink the list
    // ------------------------------------------------------------------------
    task automatic test_random_traffic();
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        int                      roll;
        bit                      grow;
        for (int phase = 0; phase < 9; phase++)
        begin
            grow     = (phase % 2 == 0);
            flat_out = (phase == 4);    // long stretch with no idling at all
            for (int n = 0; n < 100; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    op = OP_OP_UNUSED_PICK();
                else if (grow)
                    op = (roll < 38) ? OP_INSERT : (roll < 63) ? OP_APPEND :
                         (roll < 78) ? OP_GET    : (roll < 88) ? OP_LOCATE : OP_DELETE;
                else
                    op = (roll < 48) ? OP_DELETE : (roll < 60) ? OP_INSERT :
                         (roll < 68) ? OP_APPEND : (roll < 83) ? OP_GET    : OP_LOCATE;

                // mostly legal positions, the rest anywhere in the field
                if ($urandom_range(0, 99) < 80 && shadow_len > 0)
                    pos = (op == OP_INSERT) ? POS_W'($urandom_range(1, shadow_len + 1))
                                            : POS_W'($urandom_range(1, shadow_len));
                else
                    pos = POS_W'($urandom_range(0, 31));

                // small keys give locate hits and duplicates
                roll = $urandom_range(0, 99);
                if (roll < 50)
                    val = $signed(VAL_W'($urandom_range(0, 7))) - 32'sd3;
                else if (roll < 75)
                    val = $signed($urandom());
                else
                    case ($urandom_range(0, 3))
                        0:       val = 32'sh8000_0000;
                        1:       val = 32'sh7fff_ffff;
                        2:       val = -32'sd1;
                        default: val = 32'sd0;
                    endcase
                issue_request(op, pos, val);
            end
        end
        flat_out = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        req_if.valid     = 1'b0;
        req_if.operation = OP_INSERT;
        req_if.position  = '0;
        req_if.value     = '0;
        rsp_if.ready     = 1'b0;
        mismatch_count   = 0;
        cycle_count      = 0;
        flat_out         = 1'b0;
        shadow_len       = 0;
        foreach (shadow_list[i])
            shadow_list[i] = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_shifts();
        test_full_list();
        test_random_traffic();

        // stop offering requests, then let the responses drain
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
